### sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared constants and types of the box downscale averaging core.
// ----------------------------------------------------------------------------
package bda_pkg;

    // sizing
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_FACTOR  = 16;

    // field and register widths
    localparam int PIX_W       = 8;
    localparam int CFG_F_W     = 5;
    localparam int CFG_W_W     = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;

    // derived widths
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int OC_W        = COL_W + 1;
    localparam int PH_W        = $clog2(MAX_FACTOR);
    localparam int F_W         = PH_W + 1;
    localparam int SUM_W       = PIX_W + 2 * PH_W;
    localparam int FSQ_W       = 2 * PH_W + 1;
    localparam int DVD_W       = (SUM_W > OC_W) ? SUM_W : OC_W;
    localparam int CNT_W       = $clog2(DVD_W + 1);
    localparam int STORE_W     = 3 * SUM_W;

    // register reset values
    localparam int RST_FACTOR  = 2;
    localparam int RST_WIDTH   = 1024;
    localparam int RST_COLS    = RST_WIDTH / RST_FACTOR;
    localparam int RST_USABLE  = RST_COLS * RST_FACTOR;
    localparam int RST_FSQ     = RST_FACTOR * RST_FACTOR;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_start;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             row_end;
    } mean_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

    typedef struct packed {
        logic             busy;
        logic [DVD_W-1:0] quotient;
        logic [FSQ_W-1:0] remainder;
    } div_stat_t;

endpackage

### sv/box_downscale_average_core.sv
// ----------------------------------------------------------------------------
// box_downscale_average_core
// Integer box-filter downscaler for a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// A pixel in a used column is accepted while its column sum is read from
// the line store, and the next cycle adds it and writes the sum back. A
// pixel in an ignored column is accepted without leaving the idle state.
// The pixel that completes a block also runs the three channel dividers, one
// quotient bit per cycle, and their quotients are then loaded into the output
// register once it is free. The output register lets the next pixel be
// accepted while a mean waits. After a write to either register the core
// computes the column count and the used width before it accepts pixels.
module box_downscale_average_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [bda_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  bda_pkg::pixel_t                  pixel,
    output logic                             mean_valid,
    input  logic                             mean_ready,
    output bda_pkg::mean_t                   mean
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_READ = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [bda_pkg::CFG_F_W-1:0] factor_reg, factor_next;
    logic [bda_pkg::CFG_W_W-1:0] width_reg,  width_next;
    logic                        cfg_pend_reg, cfg_pend_next;
    logic [bda_pkg::F_W-1:0]     f_clamp;
    logic [bda_pkg::OC_W-1:0]    w_clamp;
    logic [bda_pkg::OC_W-1:0]    cols_reg,   cols_next;
    logic [bda_pkg::OC_W-1:0]    usable_reg, usable_next;
    logic [bda_pkg::FSQ_W-1:0]   fsq_reg,    fsq_next;

    // position counters
    logic [bda_pkg::COL_W-1:0]   ic_reg, ic_next, ic_eff;
    logic [bda_pkg::OC_W-1:0]    oc_reg, oc_next, oc_eff;
    logic [bda_pkg::PH_W-1:0]    cp_reg, cp_next, cp_eff;
    logic [bda_pkg::PH_W-1:0]    rp_reg, rp_next, rp_eff;
    logic [bda_pkg::F_W-1:0]     cp_inc, rp_inc;
    logic [bda_pkg::OC_W-1:0]    ic_inc, oc_inc;
    logic                        active, accept, block_done;

    // item in flight
    bda_pkg::pixel_t             pix_reg,     pix_next;
    logic [bda_pkg::COL_W-1:0]   addr_reg,    addr_next;
    logic                        first_reg,   first_next;
    logic                        emit_reg,    emit_next;
    logic                        rowend_reg,  rowend_next;

    // store and dividers
    bda_pkg::sum_t               rd_sum, wr_sum;
    logic                        ram_we, ram_re;
    logic                        div_start, div_cfg;
    logic [bda_pkg::DVD_W-1:0]   dvd_r, dvd_g, dvd_b;
    logic [bda_pkg::FSQ_W-1:0]   dsr;
    bda_pkg::div_stat_t          dstat_r, dstat_g, dstat_b;

    // output register
    logic                        mean_valid_reg, mean_valid_next;
    bda_pkg::mean_t              mean_reg,       mean_next;
    logic                        load_mean;

    // out-of-range register values act as the nearest legal value
    always_comb
    begin
        if (factor_reg == '0)
        begin
            f_clamp = bda_pkg::F_W'(1);
        end
        else if (int'(factor_reg) > bda_pkg::MAX_FACTOR)
        begin
            f_clamp = bda_pkg::F_W'(bda_pkg::MAX_FACTOR);
        end
        else
        begin
            f_clamp = bda_pkg::F_W'(factor_reg);
        end
        if (width_reg == '0)
        begin
            w_clamp = bda_pkg::OC_W'(1);
        end
        else if (int'(width_reg) > bda_pkg::MAX_WIDTH)
        begin
            w_clamp = bda_pkg::OC_W'(bda_pkg::MAX_WIDTH);
        end
        else
        begin
            w_clamp = bda_pkg::OC_W'(width_reg);
        end
    end

    assign pixel_ready = (state_reg == ST_IDLE) && !cfg_pend_reg && !wr_en;
    assign accept      = pixel_valid && pixel_ready;

    // counters as seen by this word, after a frame start clears them
    assign ic_eff = pixel.frame_start ? '0 : ic_reg;
    assign oc_eff = pixel.frame_start ? '0 : oc_reg;
    assign cp_eff = pixel.frame_start ? '0 : cp_reg;
    assign rp_eff = pixel.frame_start ? '0 : rp_reg;

    assign cp_inc = {1'b0, cp_eff} + 1'b1;
    assign rp_inc = {1'b0, rp_eff} + 1'b1;
    assign ic_inc = {1'b0, ic_eff} + 1'b1;
    assign oc_inc = oc_eff + 1'b1;

    assign active     = ({1'b0, ic_eff} < usable_reg)
                        && (oc_eff < bda_pkg::OC_W'(bda_pkg::MAX_WIDTH));
    assign block_done = (cp_inc >= f_clamp) && (rp_inc >= f_clamp);

    // read-modify-write of the column sum; one word at a time, so the
    // write-back always lands before the next read
    always_comb
    begin
        if (first_reg)
        begin
            wr_sum.red   = bda_pkg::SUM_W'(pix_reg.red);
            wr_sum.green = bda_pkg::SUM_W'(pix_reg.green);
            wr_sum.blue  = bda_pkg::SUM_W'(pix_reg.blue);
        end
        else
        begin
            wr_sum.red   = rd_sum.red   + bda_pkg::SUM_W'(pix_reg.red);
            wr_sum.green = rd_sum.green + bda_pkg::SUM_W'(pix_reg.green);
            wr_sum.blue  = rd_sum.blue  + bda_pkg::SUM_W'(pix_reg.blue);
        end
    end

    assign ram_re = accept && active;
    assign ram_we = (state_reg == ST_READ);

    bda_ram #(
        .WIDTH (bda_pkg::STORE_W),
        .DEPTH (bda_pkg::MAX_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wr_sum),
        .re    (ram_re),
        .raddr (oc_eff[bda_pkg::COL_W-1:0]),
        .rdata (rd_sum)
    );

    // dividers: width / factor after a register write, sum / factor^2 per block
    assign div_cfg   = (state_reg == ST_IDLE) && cfg_pend_reg;
    assign div_start = div_cfg || ((state_reg == ST_READ) && emit_reg);
    assign dvd_r     = div_cfg ? bda_pkg::DVD_W'(w_clamp) : bda_pkg::DVD_W'(wr_sum.red);
    assign dvd_g     = div_cfg ? bda_pkg::DVD_W'(w_clamp) : bda_pkg::DVD_W'(wr_sum.green);
    assign dvd_b     = div_cfg ? bda_pkg::DVD_W'(w_clamp) : bda_pkg::DVD_W'(wr_sum.blue);
    assign dsr       = div_cfg ? bda_pkg::FSQ_W'(f_clamp) : fsq_reg;

    bda_div u_div_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_r),
        .divisor  (dsr),
        .stat     (dstat_r)
    );

    bda_div u_div_g (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_g),
        .divisor  (dsr),
        .stat     (dstat_g)
    );

    bda_div u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_b),
        .divisor  (dsr),
        .stat     (dstat_b)
    );

    assign load_mean = (state_reg == ST_DIV) && !dstat_r.busy
                       && (!mean_valid_reg || mean_ready);

    always_comb
    begin
        state_next      = state_reg;
        factor_next     = factor_reg;
        width_next      = width_reg;
        cfg_pend_next   = cfg_pend_reg;
        cols_next       = cols_reg;
        usable_next     = usable_reg;
        fsq_next        = fsq_reg;
        ic_next         = ic_reg;
        oc_next         = oc_reg;
        cp_next         = cp_reg;
        rp_next         = rp_reg;
        pix_next        = pix_reg;
        addr_next       = addr_reg;
        first_next      = first_reg;
        emit_next       = emit_reg;
        rowend_next     = rowend_reg;
        mean_valid_next = mean_valid_reg;
        mean_next       = mean_reg;

        if (wr_en)
        begin
            cfg_pend_next = 1'b1;
            case (wr_index)
                bda_pkg::REG_FACTOR:
                begin
                    factor_next = wr_data[bda_pkg::CFG_F_W-1:0];
                end
                bda_pkg::REG_LINE_WIDTH:
                begin
                    width_next = wr_data[bda_pkg::CFG_W_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        if (mean_valid_reg && mean_ready)
        begin
            mean_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_pend_reg)
                begin
                    cfg_pend_next = wr_en;
                    state_next    = ST_CALC;
                end
                else if (accept)
                begin
                    pix_next    = pixel;
                    addr_next   = oc_eff[bda_pkg::COL_W-1:0];
                    first_next  = (rp_eff == '0) && (cp_eff == '0);
                    emit_next   = block_done;
                    rowend_next = ({1'b0, oc_inc} >= {1'b0, cols_reg});
                    ic_next     = ic_eff;
                    oc_next     = oc_eff;
                    cp_next     = cp_eff;
                    rp_next     = rp_eff;
                    if (active)
                    begin
                        state_next = ST_READ;
                        if (cp_inc >= f_clamp)
                        begin
                            cp_next = '0;
                            oc_next = oc_inc;
                        end
                        else
                        begin
                            cp_next = cp_inc[bda_pkg::PH_W-1:0];
                        end
                    end
                    // end of an input line
                    if (ic_inc >= w_clamp)
                    begin
                        ic_next = '0;
                        oc_next = '0;
                        cp_next = '0;
                        if (rp_inc >= f_clamp)
                        begin
                            rp_next = '0;
                        end
                        else
                        begin
                            rp_next = rp_inc[bda_pkg::PH_W-1:0];
                        end
                    end
                    else
                    begin
                        ic_next = ic_inc[bda_pkg::COL_W-1:0];
                    end
                end
            end
            ST_CALC:
            begin
                if (!dstat_r.busy)
                begin
                    cols_next   = bda_pkg::OC_W'(dstat_r.quotient);
                    usable_next = w_clamp - bda_pkg::OC_W'(dstat_r.remainder);
                    fsq_next    = bda_pkg::FSQ_W'(f_clamp * f_clamp);
                    state_next  = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = emit_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (load_mean)
                begin
                    mean_valid_next    = 1'b1;
                    mean_next.red_out   = (dstat_r.quotient > bda_pkg::DVD_W'(bda_pkg::PIX_MAX))
                                          ? bda_pkg::PIX_MAX
                                          : dstat_r.quotient[bda_pkg::PIX_W-1:0];
                    mean_next.green_out = (dstat_g.quotient > bda_pkg::DVD_W'(bda_pkg::PIX_MAX))
                                          ? bda_pkg::PIX_MAX
                                          : dstat_g.quotient[bda_pkg::PIX_W-1:0];
                    mean_next.blue_out  = (dstat_b.quotient > bda_pkg::DVD_W'(bda_pkg::PIX_MAX))
                                          ? bda_pkg::PIX_MAX
                                          : dstat_b.quotient[bda_pkg::PIX_W-1:0];
                    mean_next.row_end   = rowend_reg;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            factor_reg     <= bda_pkg::CFG_F_W'(bda_pkg::RST_FACTOR);
            width_reg      <= bda_pkg::CFG_W_W'(bda_pkg::RST_WIDTH);
            cfg_pend_reg   <= 1'b0;
            cols_reg       <= bda_pkg::OC_W'(bda_pkg::RST_COLS);
            usable_reg     <= bda_pkg::OC_W'(bda_pkg::RST_USABLE);
            fsq_reg        <= bda_pkg::FSQ_W'(bda_pkg::RST_FSQ);
            ic_reg         <= '0;
            oc_reg         <= '0;
            cp_reg         <= '0;
            rp_reg         <= '0;
            emit_reg       <= 1'b0;
            mean_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            factor_reg     <= factor_next;
            width_reg      <= width_next;
            cfg_pend_reg   <= cfg_pend_next;
            cols_reg       <= cols_next;
            usable_reg     <= usable_next;
            fsq_reg        <= fsq_next;
            ic_reg         <= ic_next;
            oc_reg         <= oc_next;
            cp_reg         <= cp_next;
            rp_reg         <= rp_next;
            emit_reg       <= emit_next;
            mean_valid_reg <= mean_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        addr_reg   <= addr_next;
        first_reg  <= first_next;
        rowend_reg <= rowend_next;
        mean_reg   <= mean_next;
    end

    assign mean_valid = mean_valid_reg;
    assign mean       = mean_reg;

`ifndef NO_ASSERTIONS
    a_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> $past(pixel_valid && pixel_ready))
        else $error("sum write-back without an accepted word");

    a_mean_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mean_valid) |-> $past(state_reg == ST_DIV))
        else $error("mean loaded outside the divide state");

    a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_ready |-> !dstat_r.busy)
        else $error("word accepted while the dividers run");

    a_usable_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && !cfg_pend_reg) |-> (usable_reg <= w_clamp))
        else $error("used width beyond line width");
`endif

endmodule

### sv/bda_ram.sv
// ----------------------------------------------------------------------------
// bda_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bda_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/bda_div.sv
// ----------------------------------------------------------------------------
// bda_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bda_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bda_pkg::DVD_W-1:0]  dividend,
    input  logic [bda_pkg::FSQ_W-1:0]  divisor,
    output bda_pkg::div_stat_t         stat
);

    logic                       busy_reg,    busy_next;
    logic [bda_pkg::CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [bda_pkg::DVD_W-1:0]  quo_reg,     quo_next;
    logic [bda_pkg::FSQ_W-1:0]  rem_reg,     rem_next;
    logic [bda_pkg::FSQ_W-1:0]  dsr_reg,     dsr_next;
    logic [bda_pkg::FSQ_W:0]    trial;
    logic                       fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[bda_pkg::DVD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bda_pkg::CNT_W'(bda_pkg::DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = bda_pkg::FSQ_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[bda_pkg::FSQ_W-1:0];
            end
            quo_next = {quo_reg[bda_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bda_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the box downscale averaging core: a queue-fed
// valid/ready driver, a randomly stalling result monitor and a
// predictor of the column sums, fed directed and random frames over several
// factor and width settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bda_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int IDLE_PCT      = 29;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    pixel_t                pixel = '0;
    logic                  mean_valid;
    logic                  mean_ready = 1'b0;
    mean_t                 mean;

    box_downscale_average_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .mean_valid  (mean_valid),
        .mean_ready  (mean_ready),
        .mean        (mean)
    );

    pixel_t pending_pixels [$];
    mean_t  expected_means [$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     src_idle_pct = IDLE_PCT;
    int     sink_idle_pct = IDLE_PCT;

    // predictor state, mirrors the core's registers and line store
    logic [CFG_F_W-1:0] cfg_factor = CFG_F_W'(RST_FACTOR);
    logic [CFG_W_W-1:0] cfg_width = CFG_W_W'(RST_WIDTH);
    sum_t               band_sums [MAX_WIDTH];
    logic [COL_W-1:0]   in_col = '0;
    logic [OC_W-1:0]    out_col = '0;
    logic [PH_W-1:0]    col_phase = '0;
    logic [PH_W-1:0]    row_phase = '0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 30)
            $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    function automatic logic [PIX_W-1:0] mean_of(input logic [SUM_W-1:0] total, input int div);
        int q;
        q = total / div;
        return (q > 255) ? PIX_MAX : q[PIX_W-1:0];
    endfunction

    // one accepted pixel: update counters and sums, queue a mean on block completion
    function automatic void advance_box_sums(input pixel_t px);
        int    f;
        int    w;
        int    cols;
        int    usable;
        int    c;
        mean_t m;
        f = cfg_factor;
        if (f < 1) f = 1;
        if (f > MAX_FACTOR) f = MAX_FACTOR;
        w = cfg_width;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        cols = w / f;
        usable = cols * f;

        if (px.frame_start)
        begin
            in_col = '0;
            out_col = '0;
            col_phase = '0;
            row_phase = '0;
        end

        if (in_col < usable && out_col < MAX_WIDTH)
        begin
            c = out_col;
            if (row_phase == 0 && col_phase == 0)
            begin
                band_sums[c].red = px.red;
                band_sums[c].green = px.green;
                band_sums[c].blue = px.blue;
            end
            else
            begin
                band_sums[c].red += px.red;
                band_sums[c].green += px.green;
                band_sums[c].blue += px.blue;
            end
            if (col_phase + 1 >= f)
            begin
                col_phase = '0;
                if (row_phase + 1 >= f)
                begin
                    m.red_out = mean_of(band_sums[c].red, f * f);
                    m.green_out = mean_of(band_sums[c].green, f * f);
                    m.blue_out = mean_of(band_sums[c].blue, f * f);
                    m.row_end = (c + 1 >= cols);
                    expected_means.push_back(m);
                end
                out_col++;
            end
            else
            begin
                col_phase++;
            end
        end

        if (in_col + 1 >= w)
        begin
            in_col = '0;
            out_col = '0;
            col_phase = '0;
            if (row_phase + 1 >= f)
                row_phase = '0;
            else
                row_phase++;
        end
        else
        begin
            in_col++;
        end
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
                advance_box_sums(pixel);
            if (!pixel_valid || pixel_ready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    pixel <= pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // mean monitor
    always @(posedge clk)
    begin : mean_monitor
        mean_t want;
        if (!rst_n)
        begin
            mean_ready <= 1'b0;
        end
        else
        begin
            if (mean_valid && mean_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    report_mismatch("word with nothing expected", int'(mean), 0);
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (mean.red_out !== want.red_out)
                        report_mismatch("red_out", mean.red_out, want.red_out);
                    if (mean.green_out !== want.green_out)
                        report_mismatch("green_out", mean.green_out, want.green_out);
                    if (mean.blue_out !== want.blue_out)
                        report_mismatch("blue_out", mean.blue_out, want.blue_out);
                    if (mean.row_end !== want.row_end)
                        report_mismatch("row_end", mean.row_end, want.row_end);
                end
            end
            mean_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value[CFG_DATA_W-1:0];
        if (idx == REG_FACTOR)
            cfg_factor = value[CFG_F_W-1:0];
        else
            cfg_width = value[CFG_W_W-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // all words through, all means back, then let the core settle
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || pixel_valid || expected_means.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic void push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                       input logic [PIX_W-1:0] b, input logic fs);
        pixel_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        px.frame_start = fs;
        pending_pixels.push_back(px);
    endfunction

    function automatic logic [PIX_W-1:0] random_channel();
        case ($urandom_range(9))
            0: return '0;
            1: return PIX_MAX;
            default: return $urandom_range(255);
        endcase
    endfunction

    // frame of random pixels, with an occasional restart in mid-frame
    function automatic void queue_frame(input int count);
        for (int i = 0; i < count; i++)
            push_pixel(random_channel(), random_channel(), random_channel(),
                       (i == 0) || ($urandom_range(149) == 0));
    endfunction

    initial
    begin
        int random_items;
        int fval;
        int wval;
        int eff_f;
        int eff_w;
        int rows;
        int trunc;
        int count;
        random_items = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // width shrunk mid-row at factor 1: column counter is past the new bound
        write_reg(REG_FACTOR, 1);
        write_reg(REG_LINE_WIDTH, 8);
        @(negedge clk);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        wait_idle();
        write_reg(REG_LINE_WIDTH, 2);
        @(negedge clk);
        push_pixel(random_channel(), random_channel(), random_channel(), 1'b0);
        push_pixel(random_channel(), random_channel(), random_channel(), 1'b0);
        wait_idle();

        // factor dropped mid-block: partial sums divided by one saturate
        write_reg(REG_FACTOR, 2);
        write_reg(REG_LINE_WIDTH, 4);
        @(negedge clk);
        push_pixel(8'd255, 8'd128, 8'd0, 1'b1);
        repeat (4) push_pixel(8'd255, 8'd128, 8'd0, 1'b0);
        wait_idle();
        write_reg(REG_FACTOR, 1);
        @(negedge clk);
        push_pixel(8'd255, 8'd128, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd128, 8'd0, 1'b0);
        wait_idle();

        // zero factor and zero width act as one
        write_reg(REG_FACTOR, 0);
        write_reg(REG_LINE_WIDTH, 0);
        @(negedge clk);
        push_pixel(8'd17, 8'd200, 8'd3, 1'b1);
        push_pixel(8'd255, 8'd0, 8'd128, 1'b0);
        wait_idle();

        // factor 3 on width 4: last column ignored
        write_reg(REG_FACTOR, 3);
        write_reg(REG_LINE_WIDTH, 4);
        @(negedge clk);
        queue_frame(12);
        wait_idle();

        // factor above the maximum acts as 16, one ignored column
        write_reg(REG_FACTOR, 31);
        write_reg(REG_LINE_WIDTH, 17);
        @(negedge clk);
        queue_frame(16 * 17);
        wait_idle();

        // full-width line at factor 1 with no idling on either side
        src_idle_pct <= 0;
        sink_idle_pct <= 0;
        write_reg(REG_FACTOR, 1 | (63 << CFG_F_W));
        write_reg(REG_LINE_WIDTH, 2047);
        @(negedge clk);
        queue_frame(MAX_WIDTH + 3);
        wait_idle();
        src_idle_pct <= IDLE_PCT;
        sink_idle_pct <= IDLE_PCT;

        // width below the factor: no usable column at all
        write_reg(REG_FACTOR, 16);
        write_reg(REG_LINE_WIDTH, 1);
        @(negedge clk);
        queue_frame(20);
        wait_idle();

        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(19))
                0, 1:    fval = 0;
                2:       fval = $urandom_range(17, 31);
                3, 4, 5: fval = $urandom_range(5, 16);
                default: fval = $urandom_range(1, 4);
            endcase
            eff_f = (fval == 0) ? 1 : (fval > MAX_FACTOR) ? MAX_FACTOR : fval;
            case ($urandom_range(19))
                0:       wval = 0;
                1, 2:    wval = (eff_f > 4) ? $urandom_range(1, 24) : $urandom_range(25, 64);
                default: wval = $urandom_range(1, 24);
            endcase
            eff_w = (wval == 0) ? 1 : wval;

            write_reg(REG_FACTOR, fval | ($urandom_range(63) << CFG_F_W));
            write_reg(REG_LINE_WIDTH, wval);
            @(negedge clk);
            repeat ($urandom_range(1, 2))
            begin
                rows = eff_f * ((eff_f * eff_w > 100) ? 1 : $urandom_range(1, 3));
                // sometimes a trailing incomplete band or a cut-off last row
                if ($urandom_range(9) < 3)
                    rows += $urandom_range(0, eff_f - 1);
                trunc = ($urandom_range(9) < 2) ? $urandom_range(1, eff_w) : 0;
                count = rows * eff_w - trunc;
                if (count < 1)
                    count = 1;
                queue_frame(count);
                random_items += count;
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
sv/bda_pkg.sv
sv/bda_ram.sv
sv/bda_div.sv
sv/box_downscale_average_core.sv
tb/testbench.sv
